// ===== src/updown_decimal_counter_display_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the up/down decimal counter display
// Shared wrappers for clocked assertions with reset disable.
// ---------------------------------------------------------------------------
`ifndef UPDOWN_DECIMAL_COUNTER_DISPLAY_UNIT_DEFINES_SVH
`define UPDOWN_DECIMAL_COUNTER_DISPLAY_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UDCD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UDCD_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/udcd_pkg.sv =====
// ---------------------------------------------------------------------------
// Up/down decimal counter display package
// Constants, register indexes and the 7-segment decoder.
// ---------------------------------------------------------------------------
package udcd_pkg;

    localparam int NUM_DIGITS_DEFAULT = 4;
    localparam int COUNT_W            = 14;
    localparam int CFG_W              = 8;
    localparam int PADDR_W            = 3;
    localparam int PDATA_W            = 32;

    localparam logic [CFG_W-1:0]   SCANS_PER_STEP_RESET = 8'd10;
    localparam logic [CFG_W-1:0]   DEBOUNCE_TICKS_RESET = 8'd50;
    localparam logic [COUNT_W-1:0] COUNT_MAX_FOUR       = 14'd9999;
    localparam logic [3:0]         BCD_NINE             = 4'd9;

    // Register index, taken from the word address of paddr.
    localparam logic REG_SCANS_PER_STEP = 1'b0;
    localparam logic REG_DEBOUNCE_TICKS = 1'b1;

    // Common-cathode pattern 0gfedcba; a non-decimal code is blank.
    function automatic logic [6:0] seg_decode(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

// ===== src/updown_decimal_counter_display_unit.sv =====
// ---------------------------------------------------------------------------
// Up/down decimal counter with multiplexed 7-segment display
// A result is registered on the output register in the cycle after its
// tick request is accepted. Throughput: one tick per cycle; the only limit
// is the single output register, which stalls the input while it is full
// and stalled. Reset clears the count, direction, scan and debounce state
// and loads the configuration registers with their defaults.
// ---------------------------------------------------------------------------
module updown_decimal_counter_display_unit #(
    parameter int NUM_DIGITS = udcd_pkg::NUM_DIGITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // tick requests
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          button_low,
    // display results
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [6:0]                    segments,
    output logic [NUM_DIGITS-1:0]         digit_select_n,
    output logic [udcd_pkg::COUNT_W-1:0]  count_value,
    output logic                          counting_down,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [udcd_pkg::PADDR_W-1:0]  paddr,
    input  logic [udcd_pkg::PDATA_W-1:0]  pwdata,
    output logic [udcd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import udcd_pkg::*;
    `include "updown_decimal_counter_display_unit_defines.svh"

    localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_DIGITS - 1);

    // Configuration registers
    logic [CFG_W-1:0] scans_per_step_reg;
    logic [CFG_W-1:0] debounce_ticks_reg;
    logic             cfg_write;
    logic             cfg_index;

    // Counter state
    logic [3:0]       digits_reg [NUM_DIGITS];
    logic [3:0]       digits_next [NUM_DIGITS];
    logic             dir_reg, dir_next;
    logic [POS_W-1:0] scan_pos_reg, scan_pos_next;
    logic [CFG_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             btn_prev_reg;
    logic [CFG_W-1:0] deb_cnt_reg, deb_cnt_next;
    logic             deb_busy_reg, deb_busy_next;

    // Output register
    logic                  out_valid_reg;
    logic [6:0]            seg_reg;
    logic [NUM_DIGITS-1:0] sel_reg;
    logic [COUNT_W-1:0]    value_reg;
    logic                  dir_out_reg;

    logic                  accept;
    logic [6:0]            seg_now;
    logic [NUM_DIGITS-1:0] sel_now;
    logic [COUNT_W-1:0]    value_now;
    logic                  step_due;

    assign accept   = in_valid && !in_stall;
    assign in_stall = out_valid_reg && out_stall;

    assign out_valid      = out_valid_reg;
    assign segments       = seg_reg;
    assign digit_select_n = sel_reg;
    assign count_value    = value_reg;
    assign counting_down  = dir_out_reg;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_index)
            REG_SCANS_PER_STEP: prdata = PDATA_W'(scans_per_step_reg);
            REG_DEBOUNCE_TICKS: prdata = PDATA_W'(debounce_ticks_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scans_per_step_reg <= SCANS_PER_STEP_RESET;
            debounce_ticks_reg <= DEBOUNCE_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SCANS_PER_STEP: scans_per_step_reg <= pwdata[CFG_W-1:0];
                REG_DEBOUNCE_TICKS: debounce_ticks_reg <= pwdata[CFG_W-1:0];
                default:            ;
            endcase
        end
    end

    // ---------------- display of the current state ----------------
    always_comb
    begin
        logic [3:0] dclamp;
        seg_now   = seg_decode(digits_reg[scan_pos_reg]);
        value_now = '0;
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            dclamp    = (digits_reg[k] > BCD_NINE) ? BCD_NINE : digits_reg[k];
            value_now = COUNT_W'((value_now << 3) + (value_now << 1))
                        + COUNT_W'(dclamp);
        end
        // Digit 0 is the most significant and drives the top select bit.
        for (int k = 0; k < NUM_DIGITS; k++)
            sel_now[k] = (scan_pos_reg != POS_W'(NUM_DIGITS - 1 - k));
    end

    // ---------------- state update for one tick ----------------
    always_comb
    begin
        logic [CFG_W-1:0] deb_dec;
        logic [CFG_W:0]   scan_inc;
        logic             carry;

        dir_next      = dir_reg;
        deb_cnt_next  = deb_cnt_reg;
        deb_busy_next = deb_busy_reg;
        deb_dec       = (deb_cnt_reg != '0) ? deb_cnt_reg - 1'b1 : deb_cnt_reg;

        if (deb_busy_reg)
        begin
            deb_cnt_next = deb_dec;
            if (deb_dec == '0)
            begin
                if (button_low)
                    dir_next = !dir_reg;
                deb_busy_next = 1'b0;
            end
        end
        else if (button_low && !btn_prev_reg)
        begin
            if (debounce_ticks_reg == '0)
                dir_next = !dir_reg;
            else
            begin
                deb_cnt_next  = debounce_ticks_reg;
                deb_busy_next = 1'b1;
            end
        end

        // The step uses the direction as updated on this same tick.
        scan_inc      = {1'b0, scan_cnt_reg} + 1'b1;
        step_due      = 1'b0;
        scan_pos_next = scan_pos_reg + 1'b1;
        scan_cnt_next = scan_cnt_reg;
        if (scan_pos_reg == POS_LAST)
        begin
            scan_pos_next = '0;
            if (scan_inc >= {1'b0, scans_per_step_reg})
            begin
                scan_cnt_next = '0;
                step_due      = 1'b1;
            end
            else
                scan_cnt_next = scan_inc[CFG_W-1:0];
        end

        // BCD ripple from the units digit toward the most significant.
        carry = step_due;
        for (int k = NUM_DIGITS - 1; k >= 0; k--)
        begin
            digits_next[k] = digits_reg[k];
            if (carry)
            begin
                if (dir_next)
                begin
                    if (digits_reg[k] == 4'd0)
                        digits_next[k] = BCD_NINE;
                    else
                    begin
                        digits_next[k] = digits_reg[k] - 1'b1;
                        carry          = 1'b0;
                    end
                end
                else
                begin
                    if (digits_reg[k] >= BCD_NINE)
                        digits_next[k] = 4'd0;
                    else
                    begin
                        digits_next[k] = digits_reg[k] + 1'b1;
                        carry          = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_DIGITS; k++)
                digits_reg[k] <= '0;
            dir_reg       <= 1'b0;
            scan_pos_reg  <= '0;
            scan_cnt_reg  <= '0;
            btn_prev_reg  <= 1'b0;
            deb_cnt_reg   <= '0;
            deb_busy_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int k = 0; k < NUM_DIGITS; k++)
                    digits_reg[k] <= digits_next[k];
                dir_reg      <= dir_next;
                scan_pos_reg <= scan_pos_next;
                scan_cnt_reg <= scan_cnt_next;
                btn_prev_reg <= button_low;
                deb_cnt_reg  <= deb_cnt_next;
                deb_busy_reg <= deb_busy_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload: loaded with the state seen at the start of the tick.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seg_reg     <= seg_now;
            sel_reg     <= sel_now;
            value_reg   <= value_now;
            dir_out_reg <= dir_reg;
        end
    end

    // ---------------- assertions ----------------
    `UDCD_ASSERT_NXT(a_accept_gives_result, accept, out_valid,
        "accepted tick did not produce a result")
    `UDCD_ASSERT_IMP(a_one_digit_driven, out_valid, $onehot(~digit_select_n),
        "digit select does not drive exactly one digit")
    `UDCD_ASSERT_IMP(a_busy_count_nonzero, deb_busy_reg, deb_cnt_reg != '0,
        "debounce wait is busy with an expired count")
    `UDCD_ASSERT_IMP(a_count_in_range, out_valid && NUM_DIGITS == 4,
        count_value <= COUNT_MAX_FOUR, "count left the decimal range")
    `UDCD_ASSERT_NXT(a_scan_advances, accept && scan_pos_reg != POS_LAST,
        scan_pos_reg == POS_W'($past(scan_pos_reg) + 1'b1),
        "scan position did not advance by one digit")

endmodule

// ===== sim/updown_decimal_counter_display_unit_test.sv =====
// ---------------------------------------------------------------------------
// Up/down decimal counter display testbench
// Sends tick requests with button levels and checks every
// display result against a cycle-free model of the BCD count, the digit
// scan and the debounce logic. Both sides idle and stall at random, and
// the configuration is changed between phases through the APB port.
// ---------------------------------------------------------------------------
module updown_decimal_counter_display_unit_test;

    import udcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [6:0] SEG_PATTERN [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct packed {
        logic [6:0]         segments;
        logic [3:0]         digit_select_n;
        logic [COUNT_W-1:0] count_value;
        logic               counting_down;
    } display_result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                button_low;
    logic                out_valid;
    logic                out_stall;
    logic [6:0]          segments;
    logic [3:0]          digit_select_n;
    logic [COUNT_W-1:0]  count_value;
    logic                counting_down;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Display model state and configuration copy.
    logic [3:0] count_digit [4];
    logic       dir_down;
    logic [1:0] scan_pos;
    logic [7:0] scan_count;
    logic       btn_prev;
    logic [7:0] debounce_left;
    logic       debounce_busy;
    logic [7:0] cfg_scans_per_step;
    logic [7:0] cfg_debounce_ticks;

    display_result_t expected_display_q [$];

    bit idling;
    int hold_cycles_req;
    int error_count;
    int tick_count;
    int result_count;
    int step_total;
    int wrap_total;
    int toggle_total;
    int quiet_cycles;

    updown_decimal_counter_display_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .button_low     (button_low),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .segments       (segments),
        .digit_select_n (digit_select_n),
        .count_value    (count_value),
        .counting_down  (counting_down),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int idle_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // One tick of the display: form the result from the current state, then
    // handle the button, then advance the scan and step the count.
    task automatic predict_display_tick(input logic btn);
        display_result_t res;
        logic [3:0]      shown;
        logic            carry;
        int              k;
        shown = count_digit[scan_pos];
        res.segments = (shown <= 4'd9) ? SEG_PATTERN[shown] : 7'h00;
        res.digit_select_n = ~(4'b1000 >> scan_pos);
        res.count_value = COUNT_W'(count_digit[0] * 1000 + count_digit[1] * 100
                                   + count_digit[2] * 10 + count_digit[3]);
        res.counting_down = dir_down;
        expected_display_q.push_back(res);

        if (debounce_busy)
        begin
            if (debounce_left > 8'd0)
                debounce_left = debounce_left - 8'd1;
            if (debounce_left == 8'd0)
            begin
                if (btn)
                begin
                    dir_down = !dir_down;
                    toggle_total++;
                end
                debounce_busy = 1'b0;
            end
        end
        else if (btn && !btn_prev)
        begin
            if (cfg_debounce_ticks == 8'd0)
            begin
                dir_down = !dir_down;
                toggle_total++;
            end
            else
            begin
                debounce_left = cfg_debounce_ticks;
                debounce_busy = 1'b1;
            end
        end
        btn_prev = btn;

        if (scan_pos == 2'd3)
        begin
            scan_pos = 2'd0;
            // A register value of zero behaves like one.
            if (int'(scan_count) + 1 >= int'(cfg_scans_per_step))
            begin
                scan_count = 8'd0;
                step_total++;
                carry = 1'b1;
                for (k = 3; k >= 0; k--)
                begin
                    if (carry)
                    begin
                        if (dir_down)
                        begin
                            if (count_digit[k] == 4'd0)
                                count_digit[k] = 4'd9;
                            else
                            begin
                                count_digit[k] = count_digit[k] - 4'd1;
                                carry = 1'b0;
                            end
                        end
                        else
                        begin
                            if (count_digit[k] >= 4'd9)
                                count_digit[k] = 4'd0;
                            else
                            begin
                                count_digit[k] = count_digit[k] + 4'd1;
                                carry = 1'b0;
                            end
                        end
                    end
                end
                if (carry)
                    wrap_total++;
            end
            else
                scan_count = scan_count + 8'd1;
        end
        else
            scan_pos = scan_pos + 2'd1;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_display_tick(button_low);
            tick_count++;
        end
    end

    always @(posedge clk)
    begin : result_check
        display_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (expected_display_q.size() == 0)
            begin
                $display("%0t: display result with no tick request pending", $time);
                error_count++;
            end
            else
            begin
                want = expected_display_q.pop_front();
                check_field("segments", want.segments, segments);
                check_field("digit_select_n", want.digit_select_n, digit_select_n);
                check_field("count_value", want.count_value, count_value);
                check_field("counting_down", want.counting_down, counting_down);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_display_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side stall: random gaps while idling, plus a long hold-off on demand.
    initial
    begin : result_stall_gen
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles_req > 0)
            begin
                n = hold_cycles_req;
                hold_cycles_req = 0;
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (idling && $urandom_range(0, 3) == 0)
            begin
                n = idle_gap();
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Called and returning at a falling edge; valid stays high on return.
    task automatic send_tick(input logic btn);
        int gap;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            gap = idle_gap();
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        button_low <= btn;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        wait (expected_display_q.size() == 0);
        repeat (3) @(negedge clk);
    endtask

    // Write one register, then read it back.
    task automatic write_register(input logic index, input logic [7:0] value);
        paddr <= {index, 2'b00};
        pwdata <= {24'($urandom_range(0, 32'hFFFFFF)), value};
        pwrite <= 1'b1;
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("register readback", value, prdata[7:0]);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (index == REG_SCANS_PER_STEP)
            cfg_scans_per_step = value;
        else
            cfg_debounce_ticks = value;
    endtask

    task automatic test_reset_defaults();
        idling = 1'b0;
        repeat (4) send_tick(1'b0);
    endtask

    // One step per scan and no debounce: a press turns the count around at
    // once, so it wraps from zero down to all nines and back up again.
    task automatic test_count_wrap();
        drain_results();
        write_register(REG_SCANS_PER_STEP, 8'd1);
        write_register(REG_DEBOUNCE_TICKS, 8'd0);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
    endtask

    // Held press toggles, short press does not, and a press during the wait
    // is dropped while the recheck still sees the button down.
    task automatic test_debounce_recheck();
        localparam bit [14:0] PRESS_PATTERN = 15'b111101100101110;
        int i;
        drain_results();
        write_register(REG_DEBOUNCE_TICKS, 8'd3);
        idling = 1'b1;
        for (i = 14; i >= 0; i--)
            send_tick(PRESS_PATTERN[i]);
    endtask

    task automatic test_back_pressure();
        drain_results();
        idling = 1'b0;
        hold_cycles_req = 120;
        repeat (30) send_tick(1'($urandom_range(0, 1)));
        drain_results();
    endtask

    // Mostly whole presses with random hold and release times, some of them
    // held past the recheck, mixed with single-tick noise.
    task automatic test_random_presses(input logic [7:0] scans, input logic [7:0] deb,
                                       input int budget, input bit idle);
        int sent;
        int hold;
        int rel;
        drain_results();
        write_register(REG_SCANS_PER_STEP, scans);
        write_register(REG_DEBOUNCE_TICKS, deb);
        idling = idle;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_tick(1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    hold = int'(deb) + $urandom_range(1, 3);
                else
                    hold = $urandom_range(1, int'(deb) + 2);
                rel = $urandom_range(1, 8);
                repeat (hold) send_tick(1'b1);
                repeat (rel) send_tick(1'b0);
                sent += hold + rel;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        button_low = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idling = 1'b0;
        hold_cycles_req = 0;
        foreach (count_digit[k])
            count_digit[k] = 4'd0;
        dir_down = 1'b0;
        scan_pos = 2'd0;
        scan_count = 8'd0;
        btn_prev = 1'b0;
        debounce_left = 8'd0;
        debounce_busy = 1'b0;
        cfg_scans_per_step = SCANS_PER_STEP_RESET;
        cfg_debounce_ticks = DEBOUNCE_TICKS_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_count_wrap();
        test_debounce_recheck();
        test_back_pressure();
        test_random_presses(8'd1, 8'd0, 30, 1'b1);
        test_random_presses(8'd1, 8'd4, 30, 1'b0);
        test_random_presses(8'd2, 8'd1, 30, 1'b1);
        test_random_presses(8'd0, 8'd9, 30, 1'b1);
        test_random_presses(8'd4, 8'd20, 30, 1'b1);
        test_random_presses(8'd255, 8'd255, 60, 1'b1);
        test_random_presses(8'($urandom_range(1, 3)), 8'($urandom_range(0, 15)), 30, 1'b1);
        drain_results();

        $display("Ran %0d tick requests and checked %0d display results.",
                 tick_count, result_count);
        $display("The count stepped %0d times with %0d wraps; direction changed %0d times.",
                 step_total, wrap_total, toggle_total);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
